@@ rtl/core/rhkv_pkg.sv @@
// Shared types, codes and hash helpers for the Robin Hood key-value table.
package rhkv_pkg;

    localparam int unsigned HOME_W    = 16;
    localparam int unsigned FILL_W    = 10;
    localparam int unsigned LIVE_W    = 11;
    localparam int unsigned IN_DATA_W  = 208;
    localparam int unsigned OUT_DATA_W = 88;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [9:0]  FILL_RESET = 10'd768;

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_COUNT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0]       key;
        logic [3:0]        klen;
        logic [63:0]       value;
        logic [3:0]        vlen;
        logic [63:0]       version;
        logic [HOME_W-1:0] home;
        logic              occ;
        logic              del;
    } slot_rec_t;

    // multiply by the FNV prime 2^40 + 0x1B3, as shifts and adds
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    endfunction

    // zero every byte at or above n
    function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) >= n) begin
                r[8*i +: 8] = 8'h00;
            end
        end
        keep_bytes = r;
    endfunction

endpackage

@@ rtl/core/rhkv_hash.sv @@
// Byte-serial FNV-1a 64 hash unit, one key byte per cycle.
module rhkv_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] key,
    input  logic [3:0]  klen,
    output logic        done,
    output logic [63:0] hash
);

    logic [63:0] h_reg, h_next;
    logic [63:0] sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;

    always_comb begin
        h_next   = h_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done     = run_reg && (cnt_reg == 4'd0);
        if (start) begin
            h_next   = rhkv_pkg::FNV_BASIS;
            sh_next  = key;
            cnt_next = klen;
            run_next = 1'b1;
        end else if (run_reg) begin
            if (cnt_reg != 4'd0) begin
                h_next   = rhkv_pkg::fnv_mul(h_reg ^ {56'd0, sh_reg[7:0]});
                sh_next  = sh_reg >> 8;
                cnt_next = cnt_reg - 4'd1;
            end else begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= 4'd0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        h_reg  <= h_next;
        sh_reg <= sh_next;
    end

    assign hash = h_reg;

endmodule

@@ rtl/core/rhkv_slot_mem.sv @@
// Slot store: one write port, one registered read port.
module rhkv_slot_mem #(
    parameter int unsigned SLOT_COUNT = 1024
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
    input  rhkv_pkg::slot_rec_t           wr_data,
    input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
    output rhkv_pkg::slot_rec_t           rd_data
);

    rhkv_pkg::slot_rec_t mem [SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/robin_hood_kv_table.sv @@
// Robin Hood key-value table: top level with the probe sequencer.
// Flow: accept, hashing of the key bytes, a read issue, probing slot by slot,
// then the output register; count and rejected items go from accept straight
// to the output register. One item at a time: an item passes through the slot
// memory (one write port, one registered read port) before the next is taken.
// Reset: synchronous active-low; afterwards a clearing pass over all SLOT_COUNT
// slots zeroes the slot flags, during which no item is taken.
module robin_hood_kv_table #(
    parameter int unsigned SLOT_COUNT      = 1024,
    parameter int unsigned KEY_MAX_BYTES   = 8,
    parameter int unsigned VALUE_MAX_BYTES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // tdata: func[1:0], key_bytes[65:2], key_length[69:66], value_bytes[133:70],
    //        value_length[137:134], version_in[201:138], zero pad[207:202]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [207:0] s_tdata,
    // tdata: status[1:0], found_value[65:2], found_length[69:66],
    //        live_count[80:70], zero pad[87:81]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,
    // fill_limit write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [9:0]   cfg_data
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);
    localparam logic [3:0] KMAX = 4'(KEY_MAX_BYTES);
    localparam logic [3:0] VMAX = 4'(VALUE_MAX_BYTES);

    rhkv_pkg::state_t state_reg, state_next;

    // input item fields
    logic [1:0]  in_func;
    logic [63:0] in_key, in_val, in_ver;
    logic [3:0]  in_klen, in_vlen;
    assign in_func = s_tdata[1:0];
    assign in_key  = s_tdata[65:2];
    assign in_klen = s_tdata[69:66];
    assign in_val  = s_tdata[133:70];
    assign in_vlen = s_tdata[137:134];
    assign in_ver  = s_tdata[201:138];

    // operation and carried entry (the item's own entry until a swap)
    logic [1:0]       func_reg, func_next;
    logic [63:0]      key_reg, key_next, val_reg, val_next, ver_reg, ver_next;
    logic [3:0]       klen_reg, klen_next, vlen_reg, vlen_next;
    logic [IDX_W-1:0] home_reg, home_next, idx_reg, idx_next;
    logic [CNT_W-1:0] dist_reg, dist_next, n_reg, n_next;
    logic             own_reg, own_next;

    // table counters and clock
    logic [CNT_W-1:0] used_reg, used_next, del_reg, del_next;
    logic [63:0]      clock_reg, clock_next;
    logic [9:0]       fill_reg;

    // result
    logic [1:0]  rstat_reg, rstat_next;
    logic [63:0] rval_reg, rval_next;
    logic [3:0]  rlen_reg, rlen_next;
    logic [10:0] rlive_reg, rlive_next;
    logic        mvalid_reg, mvalid_next;
    logic [87:0] mdata_reg, mdata_next;

    // hash unit
    logic        hash_start, hash_done;
    logic [63:0] hash_val;

    // slot memory
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    rhkv_pkg::slot_rec_t mem_wdata, rd;

    logic             match, klen_ok, full;
    logic [IDX_W-1:0] od_raw;
    logic [CNT_W-1:0] od;

    rhkv_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (rhkv_pkg::keep_bytes(in_key, in_klen)),
        .klen    (in_klen),
        .done    (hash_done),
        .hash    (hash_val)
    );

    // probing reads one slot ahead of the probed slot
    assign mem_raddr = (state_reg == rhkv_pkg::ST_PROBE) ? idx_reg + IDX_W'(1) : idx_reg;

    rhkv_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd)
    );

    assign match   = (rd.klen == klen_reg) && (rd.key == key_reg);
    assign od_raw  = idx_reg - rd.home[IDX_W-1:0];
    assign od      = {1'b0, od_raw};
    assign klen_ok = (in_klen != 4'd0) && (in_klen <= KMAX);
    assign full    = (32'(used_reg) + 32'(del_reg) > 32'(fill_reg)) ||
                     ((used_reg >= SLOTS) && (del_reg == '0));

    assign s_tready  = (state_reg == rhkv_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        klen_next   = klen_reg;
        val_next    = val_reg;
        vlen_next   = vlen_reg;
        ver_next    = ver_reg;
        home_next   = home_reg;
        idx_next    = idx_reg;
        dist_next   = dist_reg;
        n_next      = n_reg;
        own_next    = own_reg;
        used_next   = used_reg;
        del_next    = del_reg;
        clock_next  = clock_reg;
        rstat_next  = rstat_reg;
        rval_next   = rval_reg;
        rlen_next   = rlen_reg;
        rlive_next  = rlive_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        hash_start  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = '{key: key_reg, klen: klen_reg, value: val_reg, vlen: vlen_reg,
                        version: ver_reg, home: rhkv_pkg::HOME_W'(home_reg),
                        occ: 1'b1, del: 1'b0};

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            rhkv_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(SLOT_COUNT - 1)) begin
                    state_next = rhkv_pkg::ST_IDLE;
                end
            end

            rhkv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = in_func;
                    key_next   = rhkv_pkg::keep_bytes(in_key, in_klen);
                    klen_next  = in_klen;
                    val_next   = rhkv_pkg::keep_bytes(in_val, in_vlen);
                    vlen_next  = in_vlen;
                    rstat_next = rhkv_pkg::STATUS_OK;
                    rval_next  = '0;
                    rlen_next  = '0;
                    rlive_next = '0;
                    state_next = rhkv_pkg::ST_DONE;
                    priority if (in_func == rhkv_pkg::FUNC_COUNT) begin
                        rlive_next = 11'(used_reg - del_reg);
                    end else if (!klen_ok) begin
                        rstat_next = rhkv_pkg::STATUS_INVALID;
                    end else if (in_func == rhkv_pkg::FUNC_PUT) begin
                        if (in_vlen > VMAX) begin
                            rstat_next = rhkv_pkg::STATUS_INVALID;
                        end else if (full) begin
                            rstat_next = rhkv_pkg::STATUS_FULL;
                        end else begin
                            if (in_ver != 64'd0) begin
                                ver_next = in_ver;
                            end else begin
                                ver_next   = clock_reg;
                                clock_next = clock_reg + 64'd1;
                            end
                            hash_start = 1'b1;
                            state_next = rhkv_pkg::ST_HASH;
                        end
                    end else begin
                        hash_start = 1'b1;
                        state_next = rhkv_pkg::ST_HASH;
                    end
                end
            end

            rhkv_pkg::ST_HASH: begin
                if (hash_done) begin
                    idx_next   = hash_val[IDX_W-1:0];
                    home_next  = hash_val[IDX_W-1:0];
                    dist_next  = '0;
                    n_next     = '0;
                    own_next   = 1'b1;
                    state_next = rhkv_pkg::ST_ISSUE;
                end
            end

            rhkv_pkg::ST_ISSUE: begin
                state_next = rhkv_pkg::ST_PROBE;
            end

            rhkv_pkg::ST_PROBE: begin
                idx_next  = idx_reg + IDX_W'(1);
                dist_next = dist_reg + CNT_W'(1);
                n_next    = n_reg + CNT_W'(1);
                if (n_reg == SLOTS) begin
                    // whole table walked
                    rstat_next = (func_reg == rhkv_pkg::FUNC_PUT) ? rhkv_pkg::STATUS_OK
                                                                  : rhkv_pkg::STATUS_NOT_FOUND;
                    state_next = rhkv_pkg::ST_DONE;
                end else if (func_reg == rhkv_pkg::FUNC_PUT) begin
                    if (!rd.occ || rd.del) begin
                        mem_we = 1'b1;
                        if (!rd.occ) used_next = used_reg + CNT_W'(1);
                        if (rd.del)  del_next  = del_reg - CNT_W'(1);
                        state_next = rhkv_pkg::ST_DONE;
                    end else if (own_reg && match) begin
                        if (ver_reg >= rd.version) begin
                            mem_we    = 1'b1;
                            mem_wdata = rd;
                            mem_wdata.value   = val_reg;
                            mem_wdata.vlen    = vlen_reg;
                            mem_wdata.version = ver_reg;
                        end
                        state_next = rhkv_pkg::ST_DONE;
                    end else if (dist_reg > od) begin
                        // richer occupant: drop carried entry here, carry it on
                        mem_we    = 1'b1;
                        key_next  = rd.key;
                        klen_next = rd.klen;
                        val_next  = rd.value;
                        vlen_next = rd.vlen;
                        ver_next  = rd.version;
                        home_next = rd.home[IDX_W-1:0];
                        dist_next = od + CNT_W'(1);
                        own_next  = 1'b0;
                    end
                end else begin
                    if (!rd.occ || (od < dist_reg)) begin
                        rstat_next = rhkv_pkg::STATUS_NOT_FOUND;
                        state_next = rhkv_pkg::ST_DONE;
                    end else if (func_reg == rhkv_pkg::FUNC_GET) begin
                        if (!rd.del && match) begin
                            rval_next  = rd.value;
                            rlen_next  = rd.vlen;
                            state_next = rhkv_pkg::ST_DONE;
                        end
                    end else if (match) begin
                        // delete: tombstone once, again is a no-op
                        if (!rd.del) begin
                            mem_we    = 1'b1;
                            mem_wdata = rd;
                            mem_wdata.del = 1'b1;
                            del_next  = del_reg + CNT_W'(1);
                        end
                        state_next = rhkv_pkg::ST_DONE;
                    end
                end
            end

            rhkv_pkg::ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, rlive_reg, rlen_reg, rval_reg, rstat_reg};
                    state_next  = rhkv_pkg::ST_IDLE;
                end
            end

            default: state_next = rhkv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rhkv_pkg::ST_CLEAR;
            idx_reg    <= '0;
            used_reg   <= '0;
            del_reg    <= '0;
            clock_reg  <= 64'd1;
            fill_reg   <= rhkv_pkg::FILL_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            used_reg   <= used_next;
            del_reg    <= del_next;
            clock_reg  <= clock_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid) begin
                fill_reg <= cfg_data;
            end
        end
        func_reg  <= func_next;
        key_reg   <= key_next;
        klen_reg  <= klen_next;
        val_reg   <= val_next;
        vlen_reg  <= vlen_next;
        ver_reg   <= ver_next;
        home_reg  <= home_next;
        dist_reg  <= dist_next;
        n_reg     <= n_next;
        own_reg   <= own_next;
        rstat_reg <= rstat_next;
        rval_reg  <= rval_next;
        rlen_reg  <= rlen_next;
        rlive_reg <= rlive_next;
        mdata_reg <= mdata_next;
    end

endmodule

@@ rtl/core/rhkv_checker.sv @@
// Port-level checker for the key-value table, bound to the top level.
module rhkv_port_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [87:0]  m_tdata
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready after accept");

    // only a successful get carries a value
    a_value_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != rhkv_pkg::STATUS_OK) |->
            (m_tdata[65:2] == 64'd0) && (m_tdata[69:66] == 4'd0))
        else $error("value with non-ok status");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[69:66] <= 4'd8) && (m_tdata[87:81] == 7'd0))
        else $error("bad length or padding");

endmodule

bind robin_hood_kv_table rhkv_port_checker u_rhkv_checker (.*);

@@ test/rhkv_checker.sv @@
// Checker for the key-value table: predicts each item's result and compares.
module rhkv_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [207:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [9:0]   cfg_data,
    output int           mismatches,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 1024;
    localparam logic [63:0] FNV_PRIME_C = 64'd1099511628211;

    typedef struct packed {
        rhkv_pkg::status_t status;
        logic [63:0]       fvalue;
        logic [3:0]        flen;
        logic [10:0]       live;
    } answer_t;

    logic [63:0] tk_key   [SLOTS];
    logic [3:0]  tk_klen  [SLOTS];
    logic [63:0] tk_val   [SLOTS];
    logic [3:0]  tk_vlen  [SLOTS];
    logic [63:0] tk_ver   [SLOTS];
    logic [9:0]  tk_home  [SLOTS];
    logic        tk_occ   [SLOTS];
    logic        tk_del   [SLOTS];
    int unsigned n_used, n_dead;
    logic [63:0] ver_clock;
    logic [9:0]  limit_reg;

    answer_t answers_due[$];

    function automatic logic [63:0] trim(logic [63:0] v, logic [3:0] n);
        if (n >= 4'd8) return v;
        return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [9:0] home_of(logic [63:0] k, logic [3:0] n);
        logic [63:0] h;
        h = rhkv_pkg::FNV_BASIS;
        for (int i = 0; i < n && i < 8; i++) begin
            h = (h ^ ((k >> (8 * i)) & 64'hFF)) * FNV_PRIME_C;
        end
        return h[9:0];
    endfunction

    function automatic logic [9:0] dist_of(logic [9:0] idx);
        return idx - tk_home[idx];
    endfunction

    function automatic rhkv_pkg::status_t table_put(logic [63:0] key, logic [3:0] klen,
                                                    logic [63:0] val, logic [3:0] vlen,
                                                    logic [63:0] ver_in);
        logic [63:0] ck, cv, cver, tk, tv, tver;
        logic [3:0]  ckl, cvl, tkl, tvl;
        logic [9:0]  chome, idx, th;
        int unsigned pdist;
        bit          own;
        ck = key; cv = val; ckl = klen; cvl = vlen; own = 1; pdist = 0;
        if (n_used + n_dead > limit_reg) return rhkv_pkg::STATUS_FULL;
        if (n_used >= SLOTS && n_dead == 0) return rhkv_pkg::STATUS_FULL;
        if (ver_in != 0) begin
            cver = ver_in;
        end else begin
            cver = ver_clock;
            ver_clock = ver_clock + 64'd1;
        end
        chome = home_of(key, klen);
        idx = chome;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tk_occ[idx] || tk_del[idx]) begin
                if (!tk_occ[idx]) n_used++;
                if (tk_del[idx]) n_dead--;
                tk_key[idx] = ck; tk_klen[idx] = ckl; tk_val[idx] = cv;
                tk_vlen[idx] = cvl; tk_ver[idx] = cver; tk_home[idx] = chome;
                tk_occ[idx] = 1; tk_del[idx] = 0;
                return rhkv_pkg::STATUS_OK;
            end
            if (own && tk_klen[idx] == klen && tk_key[idx] == key) begin
                // an older version leaves the entry untouched
                if (cver >= tk_ver[idx]) begin
                    tk_val[idx] = cv; tk_vlen[idx] = cvl; tk_ver[idx] = cver;
                end
                return rhkv_pkg::STATUS_OK;
            end
            if (pdist > dist_of(idx)) begin
                tk = tk_key[idx]; tkl = tk_klen[idx]; tv = tk_val[idx];
                tvl = tk_vlen[idx]; tver = tk_ver[idx]; th = tk_home[idx];
                pdist = dist_of(idx);
                tk_key[idx] = ck; tk_klen[idx] = ckl; tk_val[idx] = cv;
                tk_vlen[idx] = cvl; tk_ver[idx] = cver; tk_home[idx] = chome;
                ck = tk; ckl = tkl; cv = tv; cvl = tvl; cver = tver; chome = th;
                own = 0;
            end
            idx = idx + 10'd1;
            pdist++;
        end
        return rhkv_pkg::STATUS_OK;
    endfunction

    // probe for the key; live_only skips tombstones (get), else they match (delete)
    function automatic int table_find(logic [63:0] key, logic [3:0] klen, bit live_only);
        logic [9:0] idx;
        idx = home_of(key, klen);
        for (int n = 0; n < SLOTS; n++) begin
            if (!tk_occ[idx] || dist_of(idx) < n) return -1;
            if (!(live_only && tk_del[idx]) && tk_klen[idx] == klen && tk_key[idx] == key)
                return idx;
            idx = idx + 10'd1;
        end
        return -1;
    endfunction

    function automatic answer_t table_step(logic [207:0] d);
        answer_t           a;
        rhkv_pkg::func_t   fn;
        logic [3:0]        klen, vlen;
        logic [63:0]       key, val;
        int                at;
        fn   = rhkv_pkg::func_t'(d[1:0]);
        klen = d[69:66];
        vlen = d[137:134];
        key  = trim(d[65:2], klen);
        val  = trim(d[133:70], vlen);
        a = '0;
        a.status = rhkv_pkg::STATUS_OK;
        if (fn == rhkv_pkg::FUNC_COUNT) begin
            a.live = 11'(n_used - n_dead);
        end else if (klen == 0 || klen > 4'd8) begin
            a.status = rhkv_pkg::STATUS_INVALID;
        end else if (fn == rhkv_pkg::FUNC_PUT) begin
            if (vlen > 4'd8) a.status = rhkv_pkg::STATUS_INVALID;
            else a.status = table_put(key, klen, val, vlen, d[201:138]);
        end else if (fn == rhkv_pkg::FUNC_GET) begin
            at = table_find(key, klen, 1);
            if (at < 0) begin
                a.status = rhkv_pkg::STATUS_NOT_FOUND;
            end else begin
                a.fvalue = tk_val[at];
                a.flen = tk_vlen[at];
            end
        end else begin
            at = table_find(key, klen, 0);
            if (at < 0) begin
                a.status = rhkv_pkg::STATUS_NOT_FOUND;
            end else if (!tk_del[at]) begin
                tk_del[at] = 1;
                n_dead++;
            end
        end
        return a;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                tk_occ[i] = 0;
                tk_del[i] = 0;
            end
            n_used = 0;
            n_dead = 0;
            ver_clock = 64'd1;
            limit_reg = rhkv_pkg::FILL_RESET;
            answers_due.delete();
            mismatches = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) limit_reg = cfg_data;
            if (s_tvalid && s_tready) answers_due.push_back(table_step(s_tdata));
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report("unexpected item", m_tdata[63:0], 64'd0);
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report("status", m_tdata[1:0], want.status);
                    if (m_tdata[65:2] != want.fvalue)
                        report("found_value", m_tdata[65:2], want.fvalue);
                    if (m_tdata[69:66] != want.flen)
                        report("found_length", m_tdata[69:66], want.flen);
                    if (m_tdata[80:70] != want.live)
                        report("live_count", m_tdata[80:70], want.live);
                end
            end
            pending = answers_due.size();
        end
    end

endmodule

@@ test/tb_robin_hood_kv_table.sv @@
// Testbench top: stimulus, flow control and verdict for the key-value table.
module tb_robin_hood_kv_table;
    timeunit 1ns;
    timeprecision 1ps;

    // idle cycles allowed: covers the clearing pass and a full-table probe
    localparam int IDLE_LIMIT = 40000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid, s_tready;
    logic [207:0] s_tdata;
    logic         m_tvalid, m_tready;
    logic [87:0]  m_tdata;
    logic         cfg_valid, cfg_ready;
    logic [9:0]   cfg_data;
    int           mismatches, pending;
    int           idle_cycles;
    int           burst_left;
    int           stall_mode;
    logic [63:0]  key_pool [64];
    logic [3:0]   klen_pool[64];

    robin_hood_kv_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    rhkv_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // receiver: stall style changes now and then, one style never stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_mode <= 0;
            m_tready   <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // watchdog: cycles with no item moving on any channel
    always @(posedge aclk) begin
        if (!aresetn)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // send one item; after a burst the valid drops for a random gap
    task automatic send(rhkv_pkg::func_t fn, logic [63:0] key, logic [3:0] klen,
                        logic [63:0] val, logic [3:0] vlen, logic [63:0] ver);
        s_tdata  <= {6'd0, ver, vlen, val, klen, key, fn};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic write_limit(logic [9:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // quiet point between phases: everything answered, valid low
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // random item; fresh_pct biases towards new keys so the table fills up
    task automatic random_item(int fresh_pct);
        logic [63:0]     key, val, ver;
        logic [3:0]      klen, vlen;
        int              r, p;
        rhkv_pkg::func_t fn;
        r = $urandom_range(0, 99);
        fn = (r < 45) ? rhkv_pkg::FUNC_PUT :
             (r < 75) ? rhkv_pkg::FUNC_GET :
             (r < 90) ? rhkv_pkg::FUNC_DELETE : rhkv_pkg::FUNC_COUNT;
        key = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 5) begin
            klen = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
        end else if (r < 5 + fresh_pct) begin
            klen = 4'($urandom_range(1, 8));
        end else begin
            // pool key, junk above its length
            p = $urandom_range(0, 63);
            klen = klen_pool[p];
            for (int i = 0; i < 8; i++)
                if (i < klen) key[8*i +: 8] = key_pool[p][8*i +: 8];
        end
        val = {$urandom, $urandom};
        vlen = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        r = $urandom_range(0, 9);
        ver = (r < 6) ? 64'd0 : (r < 9) ? 64'($urandom_range(1, 60)) : {$urandom, $urandom};
        send(fn, key, klen, val, vlen, ver);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        burst_left = 4;
        for (int i = 0; i < 64; i++) begin
            key_pool[i]  = {$urandom, $urandom};
            klen_pool[i] = 4'($urandom_range(1, 8));
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: bad lengths, widest key, versions, tombstones, counts
        send(rhkv_pkg::FUNC_PUT, 64'hAB, 4'd0, 64'h1, 4'd1, 64'd0);
        send(rhkv_pkg::FUNC_GET, 64'hAB, 4'd15, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_DELETE, 64'hAB, 4'd9, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_PUT, 64'hAB, 4'd1, 64'h1, 4'd9, 64'd0);
        send(rhkv_pkg::FUNC_PUT, '1, 4'd8, '1, 4'd8, '1);
        send(rhkv_pkg::FUNC_GET, '1, 4'd8, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_PUT, '1, 4'd8, 64'h1234, 4'd2, 64'd5);      // older: ignored
        send(rhkv_pkg::FUNC_GET, '1, 4'd8, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_PUT, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);      // empty value
        send(rhkv_pkg::FUNC_GET, 64'hFF00, 4'd1, 64'h0, 4'd0, 64'd0);   // junk above length
        send(rhkv_pkg::FUNC_PUT, 64'h0, 4'd1, '1, 4'd3, 64'd0);         // newer from clock
        send(rhkv_pkg::FUNC_GET, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_DELETE, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_DELETE, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);   // already a tombstone
        send(rhkv_pkg::FUNC_GET, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_COUNT, '1, 4'd15, '1, 4'd15, '1);
        send(rhkv_pkg::FUNC_PUT, 64'h0, 4'd1, 64'h77, 4'd1, 64'd0);     // reuses tombstone
        send(rhkv_pkg::FUNC_GET, 64'h0, 4'd1, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_DELETE, 64'h5555, 4'd2, 64'h0, 4'd0, 64'd0);
        send(rhkv_pkg::FUNC_COUNT, 64'h0, 4'd0, 64'h0, 4'd0, 64'd0);
        drain();

        // refused as full at a limit of 1
        write_limit(10'd1);
        send(rhkv_pkg::FUNC_PUT, 64'h42, 4'd1, 64'h1, 4'd1, 64'd0);
        send(rhkv_pkg::FUNC_GET, 64'h42, 4'd1, 64'h0, 4'd0, 64'd0);
        drain();

        write_limit(10'd768);
        repeat (450) random_item(10);
        drain();

        // highest limit with many fresh keys: long probe runs and swaps
        write_limit(10'd1023);
        repeat (600) random_item(60);
        drain();

        write_limit(10'($urandom_range(2, 1022)));
        repeat (180) random_item(20);
        drain();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rhkv_pkg.sv
rtl/core/rhkv_hash.sv
rtl/core/rhkv_slot_mem.sv
rtl/core/robin_hood_kv_table.sv
rtl/core/rhkv_checker.sv
test/rhkv_checker.sv
test/tb_robin_hood_kv_table.sv
